### sv/stfs_bat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STFS block address translation package
// Types, constants and helper functions shared by the translation pipeline.
// ----------------------------------------------------------------------------
package stfs_bat_pkg;

    localparam int BLOCK_W   = 24;
    localparam int ADDR_W    = 32;
    localparam int TBLK_W    = 25;
    localparam int SKIP_W    = 15;
    localparam int L0_QUOT_W = 17;
    localparam int L1_QUOT_W = 10;
    localparam int TNUM_W    = 20;
    localparam int SQUOT_W   = 6;

    localparam logic [BLOCK_W-1:0] INVALID_BLOCK = 24'hFFFFFF;

    localparam longint unsigned L0_DIV   = 64'h00AA;
    localparam longint unsigned L1_DIV   = 64'h70E4;
    localparam int              L0_SHIFT = 32;
    localparam int              L1_SHIFT = 39;
    localparam int              SK_SHIFT = 35;

    localparam longint unsigned L0_RECIP_L =
        ((64'd1 << L0_SHIFT) + L0_DIV - 64'd1) / L0_DIV;
    localparam longint unsigned L1_RECIP_L =
        ((64'd1 << L1_SHIFT) + L1_DIV - 64'd1) / L1_DIV;
    localparam longint unsigned SK_RECIP_F_L =
        ((64'd1 << SK_SHIFT) + 64'h718F - 64'd1) / 64'h718F;
    localparam longint unsigned SK_RECIP_M_L =
        ((64'd1 << SK_SHIFT) + 64'h723A - 64'd1) / 64'h723A;

    localparam logic [24:0] L0_RECIP   = 25'(L0_RECIP_L);
    localparam logic [24:0] L1_RECIP   = 25'(L1_RECIP_L);
    localparam logic [20:0] SK_RECIP_F = 21'(SK_RECIP_F_L);
    localparam logic [20:0] SK_RECIP_M = 21'(SK_RECIP_M_L);

    localparam logic CFG_PACKAGE_KIND        = 1'b0;
    localparam logic CFG_FIRST_TABLE_ADDRESS = 1'b1;

    typedef enum logic [1:0] {
        SKIP_ONE,
        SKIP_TWO,
        SKIP_THREE,
        SKIP_TEST
    } t_skip_kind;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_number;
        logic [ADDR_W-1:0]  table_address;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] data_address;
        logic [TBLK_W-1:0] level0_table_block;
        logic [TBLK_W-1:0] level1_table_block;
        logic [SKIP_W-1:0] skip_bytes;
        logic              block_invalid;
    } t_out;

    typedef struct packed {
        logic              package_kind;
        logic [ADDR_W-1:0] first_table_address;
    } t_cfg;

    typedef struct packed {
        logic [BLOCK_W-1:0]   block_number;
        logic                 block_invalid;
        logic [L0_QUOT_W-1:0] l0_quot;
        logic [L1_QUOT_W-1:0] l1_quot;
        t_skip_kind           skip_kind;
        logic [TNUM_W-1:0]    skip_tbl;
    } t_stage_a;

    typedef struct packed {
        logic [TBLK_W-1:0]    backing_block;
        logic                 block_invalid;
        logic                 l0_nonzero;
        logic [L1_QUOT_W-1:0] l1_quot;
        logic [TBLK_W-1:0]    l0_prod;
        logic [TBLK_W-1:0]    l1_prod;
        t_skip_kind           skip_kind;
        logic [TNUM_W-1:0]    skip_tbl;
        logic [SQUOT_W-1:0]   skip_quot;
    } t_stage_b;

    function automatic logic [7:0] step0(input logic kind);
        return kind ? 8'hAC : 8'hAB;
    endfunction

    function automatic logic [15:0] step1(input logic kind);
        return kind ? 16'h723A : 16'h718F;
    endfunction

    function automatic logic [1:0] table_blocks(input logic kind);
        return kind ? 2'd2 : 2'd1;
    endfunction

    function automatic logic [SKIP_W-1:0] skip_value(input t_skip_kind k, input logic kind);
        logic [SKIP_W-1:0] base;
        case (k)
            SKIP_TWO:   base = 15'h2000;
            SKIP_THREE: base = 15'h3000;
            default:    base = 15'h1000;
        endcase
        return base << kind;
    endfunction

endpackage
`default_nettype wire

### sv/stfs_bat_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STFS translation stage one
// Divides the block number by the table spacings and classifies the table
// address for the skip size.
// ----------------------------------------------------------------------------
module stfs_bat_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire stfs_bat_pkg::t_cfg    i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire stfs_bat_pkg::t_in     i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output stfs_bat_pkg::t_stage_a     o_data
);
    import stfs_bat_pkg::*;

    logic              r_valid;
    t_stage_a          r_data;
    t_stage_a          n_data;
    logic [48:0]       w_prod0;
    logic [48:0]       w_prod1;
    logic [ADDR_W-1:0] w_diff;
    logic [TNUM_W-1:0] w_tnum;
    logic [TNUM_W-1:0] w_step1;
    logic [TNUM_W-1:0] w_after;

    always_comb begin
        w_prod0 = 49'(i_data.block_number) * 49'(L0_RECIP);
        w_prod1 = 49'(i_data.block_number) * 49'(L1_RECIP);
        w_diff  = i_data.table_address - i_cfg.first_table_address;
        w_tnum  = w_diff[ADDR_W-1:12];
        w_step1 = TNUM_W'(step1(i_cfg.package_kind));
        w_after = w_step1 + TNUM_W'(table_blocks(i_cfg.package_kind));

        n_data.block_number  = i_data.block_number;
        n_data.block_invalid = (i_data.block_number == INVALID_BLOCK);
        n_data.l0_quot       = w_prod0[48:L0_SHIFT];
        n_data.l1_quot       = w_prod1[48:L1_SHIFT];
        n_data.skip_tbl      = w_tnum;
        if (w_tnum == '0) begin
            n_data.skip_kind = SKIP_ONE;
        end else if (w_tnum == w_step1) begin
            n_data.skip_kind = SKIP_THREE;
        end else if ((w_tnum > w_step1) && (w_tnum < w_after)) begin
            // The adjusted number wraps to all ones, which is never a table boundary.
            n_data.skip_kind = SKIP_ONE;
        end else begin
            n_data.skip_kind = SKIP_TEST;
        end
        if (w_tnum > w_step1) begin
            n_data.skip_tbl = w_tnum - w_after;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

### sv/stfs_bat_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STFS translation stage two
// Forms the backing block number, the table step products and the skip quotient.
// ----------------------------------------------------------------------------
module stfs_bat_mul (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire stfs_bat_pkg::t_cfg      i_cfg,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire stfs_bat_pkg::t_stage_a  i_data,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output stfs_bat_pkg::t_stage_b       o_data
);
    import stfs_bat_pkg::*;

    logic              r_valid;
    t_stage_b          r_data;
    t_stage_b          n_data;
    logic              w_kind;
    logic [17:0]       w_d0_inc;
    logic [10:0]       w_d1_inc;
    logic [TBLK_W-1:0] w_l1_term;
    logic [TBLK_W-1:0] w_l2_term;
    logic [25:0]       w_l1_prod;
    logic [40:0]       w_sq;

    always_comb begin
        w_kind    = i_cfg.package_kind;
        w_d0_inc  = 18'(i_data.l0_quot) + 18'd1;
        w_d1_inc  = 11'(i_data.l1_quot) + 11'd1;
        w_l1_term = (i_data.l0_quot != '0) ? (TBLK_W'(w_d1_inc) << w_kind) : '0;
        w_l2_term = (i_data.l1_quot != '0) ? TBLK_W'(table_blocks(w_kind)) : '0;
        w_l1_prod = 26'(i_data.l1_quot) * 26'(step1(w_kind));
        w_sq      = 41'(i_data.skip_tbl) * 41'(w_kind ? SK_RECIP_M : SK_RECIP_F);

        n_data.backing_block = TBLK_W'(i_data.block_number) + (TBLK_W'(w_d0_inc) << w_kind)
                             + w_l1_term + w_l2_term;
        n_data.block_invalid = i_data.block_invalid;
        n_data.l0_nonzero    = (i_data.l0_quot != '0);
        n_data.l1_quot       = i_data.l1_quot;
        n_data.l0_prod       = TBLK_W'(i_data.l0_quot) * TBLK_W'(step0(w_kind));
        n_data.l1_prod       = w_l1_prod[TBLK_W-1:0];
        n_data.skip_kind     = i_data.skip_kind;
        n_data.skip_tbl      = i_data.skip_tbl;
        n_data.skip_quot     = w_sq[SK_SHIFT+SQUOT_W-1:SK_SHIFT];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

### sv/stfs_bat_fin.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STFS translation stage three
// Final sums, the data address and the skip size; holds the result word.
// ----------------------------------------------------------------------------
module stfs_bat_fin (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire stfs_bat_pkg::t_cfg      i_cfg,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire stfs_bat_pkg::t_stage_b  i_data,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output stfs_bat_pkg::t_out           o_data
);
    import stfs_bat_pkg::*;

    logic              r_valid;
    t_out              r_data;
    t_out              n_data;
    logic              w_kind;
    logic [10:0]       w_d1_inc;
    logic [TBLK_W-1:0] w_l0_sum;
    logic [21:0]       w_mult;
    t_skip_kind        w_skip;

    always_comb begin
        w_kind   = i_cfg.package_kind;
        w_d1_inc = 11'(i_data.l1_quot) + 11'd1;
        w_l0_sum = i_data.l0_prod + (TBLK_W'(w_d1_inc) << w_kind)
                 + ((i_data.l1_quot != '0) ? TBLK_W'(table_blocks(w_kind)) : '0);
        w_mult   = 22'(i_data.skip_quot) * 22'(step1(w_kind));

        case (i_data.skip_kind)
            SKIP_TEST: begin
                if ((i_data.skip_tbl == TNUM_W'(step0(w_kind)))
                        || (w_mult == 22'(i_data.skip_tbl))) begin
                    w_skip = SKIP_TWO;
                end else begin
                    w_skip = SKIP_ONE;
                end
            end
            default: begin
                w_skip = i_data.skip_kind;
            end
        endcase

        n_data.data_address       = i_data.block_invalid ? '0
                                  : ({i_data.backing_block[19:0], 12'h000}
                                     + i_cfg.first_table_address);
        n_data.level0_table_block = i_data.l0_nonzero ? w_l0_sum : '0;
        n_data.level1_table_block = (i_data.l1_quot != '0)
                                  ? (TBLK_W'(table_blocks(w_kind)) + i_data.l1_prod)
                                  : TBLK_W'(step0(w_kind));
        n_data.skip_bytes         = skip_value(w_skip, w_kind);
        n_data.block_invalid      = i_data.block_invalid;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

### sv/stfs_block_address_translate_top.sv
// Pipeline: three register stages (u_div, u_mul, u_fin); a result word is
// registered in each of them in turn before it appears on o_out.
// Throughput: one word per cycle; a stage holds its word only while the stage
// after it is full and stalled, so the input stalls only when all three are full.
// Reset: synchronous, active low; clears all stage valid flags and sets the
// package kind and the first table address to zero.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STFS block address translation
// Maps a logical data block number to its byte address and table numbers.
// ----------------------------------------------------------------------------
module stfs_block_address_translate_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire stfs_bat_pkg::t_in   i_in,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output stfs_bat_pkg::t_out       o_out
);
    import stfs_bat_pkg::*;

    logic              r_package_kind;
    logic [ADDR_W-1:0] r_first_table_address;
    t_cfg              w_cfg;
    logic              w_a_valid;
    logic              w_a_ready;
    t_stage_a          w_a_data;
    logic              w_b_valid;
    logic              w_b_ready;
    t_stage_b          w_b_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_package_kind        <= 1'b0;
            r_first_table_address <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PACKAGE_KIND:        r_package_kind        <= i_cfg_data[0];
                CFG_FIRST_TABLE_ADDRESS: r_first_table_address <= i_cfg_data;
                default:                 r_package_kind        <= r_package_kind;
            endcase
        end
    end

    assign w_cfg.package_kind        = r_package_kind;
    assign w_cfg.first_table_address = r_first_table_address;

    stfs_bat_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_in),
        .o_valid (w_a_valid),
        .i_ready (w_a_ready),
        .o_data  (w_a_data)
    );

    stfs_bat_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_a_valid),
        .o_ready (w_a_ready),
        .i_data  (w_a_data),
        .o_valid (w_b_valid),
        .i_ready (w_b_ready),
        .o_data  (w_b_data)
    );

    stfs_bat_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_b_valid),
        .o_ready (w_b_ready),
        .i_data  (w_b_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_out)
    );

endmodule
`default_nettype wire

### sv/stfs_bat_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STFS translation port checker
// Watches the ports of the translation block and reports broken rules.
// ----------------------------------------------------------------------------
module stfs_bat_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                o_ready,
    input  wire logic                o_valid,
    input  wire logic                i_ready,
    input  wire stfs_bat_pkg::t_out  o_out
);
    import stfs_bat_pkg::*;

    // A result word that is not taken must be held unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.block_invalid |-> o_out.data_address == '0)
        else $error("invalid block with non-zero address");

    a_skip_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.skip_bytes == 15'h1000) || (o_out.skip_bytes == 15'h2000)
                 || (o_out.skip_bytes == 15'h3000) || (o_out.skip_bytes == 15'h4000)
                 || (o_out.skip_bytes == 15'h6000))
        else $error("skip size not a whole number of tables");

    // With the result register free the pipeline must accept a word.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !$past(i_valid) && !$past(i_valid, 2) |-> o_ready)
        else $error("input not ready while pipeline empty");

endmodule

bind stfs_block_address_translate_top stfs_bat_checker u_stfs_bat_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_out   (o_out)
);
`default_nettype wire
